FILE: design/ptbe_pkg.sv
// Shared types, codes and constants for the packed temporal binary encoder.
// No dependencies; every other design file imports this package.
package ptbe_pkg;

    // value kinds; every other code packs to zero
    localparam logic [1:0] KIND_DATETIME = 2'd0;
    localparam logic [1:0] KIND_TIME     = 2'd1;

    localparam int FRAC_BITS = 24;

    // reciprocals for exact division of a 24-bit magnitude:
    // q = (x * ceil(2^k / d)) >> k
    localparam int RECIP_W          = 25;
    localparam int PROD_W           = FRAC_BITS + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_10K = 25'd27487791;  // k = 38
    localparam int SHIFT_10K        = 38;
    localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;  // k = 31
    localparam int SHIFT_100        = 31;
    localparam int QUOT_W           = PROD_W - SHIFT_100;     // 18 bits

    // number of fraction bytes in the binary form
    localparam logic [1:0] FB_NONE  = 2'd0;
    localparam logic [1:0] FB_ONE   = 2'd1;
    localparam logic [1:0] FB_TWO   = 2'd2;
    localparam logic [1:0] FB_THREE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [9:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [19:0] usec;
        logic        neg;
        logic [2:0]  dec;
    } fields_t;

    typedef struct packed {
        logic [63:0]          nr;
        logic [1:0]           kind;
        logic [1:0]           fbytes;
        logic [FRAC_BITS-1:0] fmag;
    } pack_t;

    typedef struct packed {
        logic [63:0]       nr;
        logic [1:0]        kind;
        logic [1:0]        fbytes;
        logic [PROD_W-1:0] prod;
    } frac_t;

    function automatic logic [1:0] frac_bytes(input logic [2:0] dec);
        logic [1:0] fb;
        unique case (dec)
            3'd1, 3'd2: fb = FB_ONE;
            3'd3, 3'd4: fb = FB_TWO;
            3'd5, 3'd6: fb = FB_THREE;
            default:    fb = FB_NONE;
        endcase
        return fb;
    endfunction

endpackage

FILE: design/ptbe_pack.sv
// Builds the signed packed 64-bit value from the broken-down fields.
// Depends on ptbe_pkg.
module ptbe_pack (
    input  ptbe_pkg::fields_t f,
    output ptbe_pkg::pack_t   p
);
    import ptbe_pkg::*;

    logic [17:0] ym;
    logic [22:0] ymd;
    logic [39:0] dt_int;
    logic [10:0] hours;
    logic [22:0] tm_int;
    logic [39:0] int_part;
    logic [63:0] mag;
    logic [63:0] nr;

    always_comb
    begin
        ym     = 18'(f.year) * 18'd13 + 18'(f.month);
        ymd    = {ym, f.day};
        dt_int = {ymd, 17'd0} | 40'({f.hour, f.minute, f.second});
        hours  = ((f.month != 4'd0) ? 11'd0 : 11'(f.day) * 11'd24) + 11'(f.hour);
        tm_int = {hours, f.minute, f.second};

        unique case (f.kind)
            KIND_DATETIME: int_part = dt_int;
            KIND_TIME:     int_part = 40'(tm_int);
            default:       int_part = 40'd0;
        endcase

        // low 24 bits of the integer shift are zero, so the add is a merge
        if (f.kind == KIND_DATETIME || f.kind == KIND_TIME)
            mag = {int_part, 4'd0, f.usec};
        else
            mag = 64'd0;

        nr = f.neg ? (64'd0 - mag) : mag;

        p.nr     = nr;
        p.kind   = f.kind;
        p.fbytes = frac_bytes(f.dec);
        // magnitude of the truncated remainder by 2^24
        p.fmag   = nr[63] ? (24'd0 - nr[23:0]) : nr[23:0];
    end

endmodule

FILE: design/ptbe_frac.sv
// Scales the fraction magnitude by a reciprocal for division by 10000 or 100.
// Depends on ptbe_pkg.
module ptbe_frac (
    input  ptbe_pkg::pack_t p,
    output ptbe_pkg::frac_t q
);
    import ptbe_pkg::*;

    logic [RECIP_W-1:0] recip;

    always_comb
    begin
        recip    = (p.fbytes == FB_ONE) ? RECIP_10K : RECIP_100;
        q.nr     = p.nr;
        q.kind   = p.kind;
        q.fbytes = p.fbytes;
        q.prod   = PROD_W'(p.fmag) * PROD_W'(recip);
    end

endmodule

FILE: design/ptbe_format.sv
// Lays out the big-endian binary form and its byte count.
// Depends on ptbe_pkg.
module ptbe_format (
    input  ptbe_pkg::frac_t q,
    output logic [63:0]     packed_val,
    output logic [63:0]     bytes_val,
    output logic [3:0]      count_val
);
    import ptbe_pkg::*;

    logic              fneg;
    logic [QUOT_W-1:0] quot;
    logic [QUOT_W-1:0] squot;
    logic [23:0]       frac_field;
    logic [39:0]       int40;
    logic [23:0]       int24;
    logic [47:0]       whole48;

    always_comb
    begin
        fneg  = q.nr[63];
        quot  = (q.fbytes == FB_ONE) ? QUOT_W'(q.prod[PROD_W-1:SHIFT_10K])
                                     : q.prod[PROD_W-1:SHIFT_100];
        squot = fneg ? (QUOT_W'(0) - quot) : quot;

        // adding a power-of-two offset to the truncated field flips its top bit
        int40   = {~q.nr[63], q.nr[62:24]};
        int24   = {~q.nr[47], q.nr[46:24]};
        whole48 = {~q.nr[47], q.nr[46:0]};

        unique case (q.fbytes)
            FB_ONE:   frac_field = {squot[7:0], 16'd0};
            FB_TWO:   frac_field = {squot[15:0], 8'd0};
            FB_THREE: frac_field = q.nr[23:0];
            default:  frac_field = 24'd0;
        endcase

        packed_val = q.nr;
        unique case (q.kind)
            KIND_DATETIME:
            begin
                bytes_val = {int40, frac_field};
                count_val = 4'd5 + 4'(q.fbytes);
            end
            KIND_TIME:
            begin
                if (q.fbytes == FB_THREE)
                begin
                    bytes_val = {whole48, 16'd0};
                    count_val = 4'd6;
                end
                else
                begin
                    bytes_val = {int24, frac_field, 16'd0};
                    count_val = 4'd3 + 4'(q.fbytes);
                end
            end
            default:
            begin
                bytes_val = 64'd0;
                count_val = 4'd0;
            end
        endcase
    end

endmodule

FILE: design/packed_temporal_binary_encoder.sv
// Top level of the packed temporal binary encoder: handshake and stage registers.
// Depends on ptbe_pkg, ptbe_pack, ptbe_frac and ptbe_format.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_stall, value_kind..decimals | to block
//  out     | out_valid, out_stall, packed_value,      | from block
//          | binary_bytes, byte_count                 |
//
// One transfer per cycle sustained while the output is not stalled; a result passes through
// the input, pack, multiply and output registers in order after its input transfer.
// The fraction multiplier (24 x 25 bits) sits alone in its own stage.
// Reset clears all valid bits; payload registers are not reset.
// Each stage holds while the next one is full and stalled; empty stages fill.
module packed_temporal_binary_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  value_kind,
    input  logic [13:0] year_value,
    input  logic [3:0]  month_value,
    input  logic [4:0]  day_value,
    input  logic [9:0]  hour_value,
    input  logic [5:0]  minute_value,
    input  logic [5:0]  second_value,
    input  logic [19:0] microseconds,
    input  logic        negative_flag,
    input  logic [2:0]  decimals,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [63:0] packed_value,
    output logic [63:0] binary_bytes,
    output logic [3:0]  byte_count
);
    import ptbe_pkg::*;

    logic    in_vld_reg,   in_vld_next;
    logic    pk_vld_reg,   pk_vld_next;
    logic    fr_vld_reg,   fr_vld_next;
    logic    out_vld_reg,  out_vld_next;

    fields_t in_reg;
    pack_t   pk_reg;
    frac_t   fr_reg;
    logic [63:0] packed_reg;
    logic [63:0] bytes_reg;
    logic [3:0]  count_reg;

    fields_t     in_fields;
    pack_t       pk_comb;
    frac_t       fr_comb;
    logic [63:0] packed_comb;
    logic [63:0] bytes_comb;
    logic [3:0]  count_comb;

    logic out_rdy, fr_rdy, pk_rdy, in_rdy;

    assign in_fields = '{kind: value_kind, year: year_value, month: month_value,
                         day: day_value, hour: hour_value, minute: minute_value,
                         second: second_value, usec: microseconds,
                         neg: negative_flag, dec: decimals};

    ptbe_pack u_pack (
        .f (in_reg),
        .p (pk_comb)
    );

    ptbe_frac u_frac (
        .p (pk_reg),
        .q (fr_comb)
    );

    ptbe_format u_format (
        .q          (fr_reg),
        .packed_val (packed_comb),
        .bytes_val  (bytes_comb),
        .count_val  (count_comb)
    );

    always_comb
    begin
        out_rdy = !out_vld_reg || !out_stall;
        fr_rdy  = !fr_vld_reg  || out_rdy;
        pk_rdy  = !pk_vld_reg  || fr_rdy;
        in_rdy  = !in_vld_reg  || pk_rdy;

        out_vld_next = out_rdy ? fr_vld_reg : out_vld_reg;
        fr_vld_next  = fr_rdy  ? pk_vld_reg : fr_vld_reg;
        pk_vld_next  = pk_rdy  ? in_vld_reg : pk_vld_reg;
        in_vld_next  = in_rdy  ? in_valid   : in_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            pk_vld_reg  <= 1'b0;
            fr_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            pk_vld_reg  <= pk_vld_next;
            fr_vld_reg  <= fr_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy && in_valid)
            in_reg <= in_fields;
        if (pk_rdy && in_vld_reg)
            pk_reg <= pk_comb;
        if (fr_rdy && pk_vld_reg)
            fr_reg <= fr_comb;
        if (out_rdy && fr_vld_reg)
        begin
            packed_reg <= packed_comb;
            bytes_reg  <= bytes_comb;
            count_reg  <= count_comb;
        end
    end

    assign in_stall     = !in_rdy;
    assign out_valid    = out_vld_reg;
    assign packed_value = packed_reg;
    assign binary_bytes = bytes_reg;
    assign byte_count   = count_reg;

    // an accepted input always lands in the input stage
    a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_vld_reg)
        else $error("accepted transfer not captured");

    // only counts of 0, 3 to 6 and 5 to 8 can be produced
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count == 4'd0 || (byte_count >= 4'd3 && byte_count <= 4'd8)))
        else $error("byte count out of range");

    // an empty binary form only comes with a zero packed value
    a_other_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_count == 4'd0 |-> packed_value == 64'sd0 && binary_bytes == 64'd0)
        else $error("other kind with nonzero output");

    // bytes beyond a count of five are zero
    a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_count == 4'd5 |-> binary_bytes[23:0] == 24'd0)
        else $error("unused bytes not cleared");

    // a full pipeline with a stalled output does not accept
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && pk_vld_reg && fr_vld_reg && out_valid && out_stall |-> in_stall)
        else $error("transfer accepted into a full pipeline");

endmodule
